// ===== src/rcl_pkg.sv =====
// rcl_pkg: shared types, wiring tables and letter arithmetic for the
// three-rotor letter cipher. No dependencies; imported by every module in src.

package rcl_pkg;

  // Alphabet size and plugboard geometry
  localparam int unsigned LETTERS       = 26;
  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned PLUG_PAIR_MAX = 5;
  localparam int unsigned PLUG_PAIR_W   = 2 * LETTER_W;
  localparam int unsigned PLUG_W        = PLUG_PAIR_W * PLUG_PAIR_MAX;
  localparam int unsigned PLUG_CNT_W    = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = PLUG_W;

  typedef logic [LETTER_W-1:0] letter_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_ROTOR   = 3'd0,
    REG_MIDDLE_ROTOR = 3'd1,
    REG_SLOW_ROTOR   = 3'd2,
    REG_FAST_START   = 3'd3,
    REG_MIDDLE_START = 3'd4,
    REG_SLOW_START   = 3'd5,
    REG_PLUG_PAIRS   = 3'd6,
    REG_PLUG_COUNT   = 3'd7
  } rcl_reg_e;

  // Rotor selector: zero is a straight wire
  typedef enum logic [1:0] {
    ROTOR_NONE = 2'd0,
    ROTOR_I    = 2'd1,
    ROTOR_II   = 2'd2,
    ROTOR_III  = 2'd3
  } rcl_rotor_e;

  // Static key settings seen by the datapath
  typedef struct packed {
    rcl_rotor_e               fast_sel;
    rcl_rotor_e               middle_sel;
    rcl_rotor_e               slow_sel;
    logic [PLUG_W-1:0]        plug_pairs;
    logic [PLUG_CNT_W-1:0]    plug_count;
  } rcl_cfg_t;

  // Rotor positions used for one letter
  typedef struct packed {
    letter_t slow;
    letter_t middle;
    letter_t fast;
  } rcl_pos_t;

  // Forward wirings I, II, III
  localparam letter_t ROTOR_FWD [0:2][0:LETTERS-1] = '{
    '{5'd15, 5'd4,  5'd25, 5'd20, 5'd14, 5'd7,  5'd23, 5'd18, 5'd2,  5'd21, 5'd5,  5'd12, 5'd19,
      5'd1,  5'd6,  5'd11, 5'd17, 5'd8,  5'd13, 5'd16, 5'd9,  5'd22, 5'd0,  5'd24, 5'd3,  5'd10},
    '{5'd25, 5'd14, 5'd20, 5'd4,  5'd18, 5'd24, 5'd3,  5'd10, 5'd5,  5'd22, 5'd15, 5'd2,  5'd8,
      5'd16, 5'd23, 5'd7,  5'd12, 5'd21, 5'd1,  5'd11, 5'd6,  5'd13, 5'd9,  5'd17, 5'd0,  5'd19},
    '{5'd4,  5'd7,  5'd17, 5'd21, 5'd23, 5'd6,  5'd0,  5'd14, 5'd1,  5'd16, 5'd20, 5'd18, 5'd8,
      5'd12, 5'd25, 5'd5,  5'd11, 5'd24, 5'd13, 5'd22, 5'd10, 5'd19, 5'd15, 5'd3,  5'd9,  5'd2}
  };

  // Inverse wirings I, II, III
  localparam letter_t ROTOR_INV [0:2][0:LETTERS-1] = '{
    '{5'd22, 5'd13, 5'd8,  5'd24, 5'd1,  5'd10, 5'd14, 5'd5,  5'd17, 5'd20, 5'd25, 5'd15, 5'd11,
      5'd18, 5'd4,  5'd0,  5'd19, 5'd16, 5'd7,  5'd12, 5'd3,  5'd9,  5'd21, 5'd6,  5'd23, 5'd2},
    '{5'd24, 5'd18, 5'd11, 5'd6,  5'd3,  5'd8,  5'd20, 5'd15, 5'd12, 5'd22, 5'd7,  5'd19, 5'd16,
      5'd21, 5'd1,  5'd10, 5'd13, 5'd23, 5'd4,  5'd25, 5'd2,  5'd17, 5'd9,  5'd14, 5'd5,  5'd0},
    '{5'd6,  5'd8,  5'd25, 5'd23, 5'd0,  5'd15, 5'd5,  5'd1,  5'd12, 5'd24, 5'd20, 5'd16, 5'd13,
      5'd18, 5'd7,  5'd22, 5'd9,  5'd2,  5'd11, 5'd21, 5'd10, 5'd3,  5'd19, 5'd4,  5'd17, 5'd14}
  };

  // UKW-K reflector
  localparam letter_t REFLECT [0:LETTERS-1] = '{
    5'd8,  5'd12, 5'd4,  5'd19, 5'd2,  5'd6,  5'd5,  5'd17, 5'd0,  5'd24, 5'd18, 5'd16, 5'd1,
    5'd25, 5'd23, 5'd22, 5'd11, 5'd7,  5'd10, 5'd3,  5'd21, 5'd20, 5'd15, 5'd14, 5'd9,  5'd13
  };

  // Bring a 5-bit code 26..31 back into the alphabet
  function automatic letter_t fold_letter(input logic [LETTER_W-1:0] x);
    return (x > 5'd25) ? x - 5'd26 : x;
  endfunction

  function automatic letter_t inc_mod26(input letter_t a);
    return (a == 5'd25) ? 5'd0 : a + 5'd1;
  endfunction

  function automatic letter_t add_mod26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'd26) ? LETTER_W'(s - 6'd26) : s[LETTER_W-1:0];
  endfunction

  function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + 6'd26 - {1'b0, b};
    return (a >= b) ? a - b : s[LETTER_W-1:0];
  endfunction

  // Entry side to reflector side through one slot
  function automatic letter_t rotor_fwd(input rcl_rotor_e sel, input letter_t pos,
                                        input letter_t c);
    letter_t idx;
    idx = add_mod26(c, pos);
    case (sel)
      ROTOR_I:   return ROTOR_FWD[0][idx];
      ROTOR_II:  return ROTOR_FWD[1][idx];
      ROTOR_III: return ROTOR_FWD[2][idx];
      default:   return c;
    endcase
  endfunction

  // Reflector side back to entry side through one slot
  function automatic letter_t rotor_rev(input rcl_rotor_e sel, input letter_t pos,
                                        input letter_t c);
    case (sel)
      ROTOR_I:   return sub_mod26(ROTOR_INV[0][c], pos);
      ROTOR_II:  return sub_mod26(ROTOR_INV[1][c], pos);
      ROTOR_III: return sub_mod26(ROTOR_INV[2][c], pos);
      default:   return c;
    endcase
  endfunction

  function automatic logic [PLUG_CNT_W-1:0] pairs_in_use(input logic [PLUG_CNT_W-1:0] cnt);
    return (cnt > PLUG_CNT_W'(PLUG_PAIR_MAX)) ? PLUG_CNT_W'(PLUG_PAIR_MAX) : cnt;
  endfunction

  // Plugboard, entry direction: pairs applied in order, from -> to
  function automatic letter_t plug_fwd(input logic [PLUG_W-1:0] pairs,
                                       input logic [PLUG_CNT_W-1:0] cnt,
                                       input letter_t c);
    letter_t                 r;
    letter_t                 from_l;
    letter_t                 to_l;
    logic [PLUG_CNT_W-1:0]   n;
    r = c;
    n = pairs_in_use(cnt);
    for (int i = 0; i < PLUG_PAIR_MAX; i++) begin
      from_l = fold_letter(pairs[i*PLUG_PAIR_W +: LETTER_W]);
      to_l   = fold_letter(pairs[i*PLUG_PAIR_W + LETTER_W +: LETTER_W]);
      if ((PLUG_CNT_W'(i) < n) && (r == from_l)) r = to_l;
    end
    return r;
  endfunction

  // Plugboard, exit direction: same order, to -> from
  function automatic letter_t plug_rev(input logic [PLUG_W-1:0] pairs,
                                       input logic [PLUG_CNT_W-1:0] cnt,
                                       input letter_t c);
    letter_t                 r;
    letter_t                 from_l;
    letter_t                 to_l;
    logic [PLUG_CNT_W-1:0]   n;
    r = c;
    n = pairs_in_use(cnt);
    for (int i = 0; i < PLUG_PAIR_MAX; i++) begin
      from_l = fold_letter(pairs[i*PLUG_PAIR_W +: LETTER_W]);
      to_l   = fold_letter(pairs[i*PLUG_PAIR_W + LETTER_W +: LETTER_W]);
      if ((PLUG_CNT_W'(i) < n) && (r == to_l)) r = from_l;
    end
    return r;
  endfunction

endpackage

// ===== src/rcl_rotor_path.sv =====
// rcl_rotor_path: three-stage letter pipeline (input register, forward pass
// plus reflector, reverse pass) with per-stage valid/ready. Depends on rcl_pkg.

module rcl_rotor_path
  import rcl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rcl_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  letter_t  in_letter_i,
  input  rcl_pos_t in_pos_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output letter_t  out_letter_o
);

  logic     s1_valid_q, s2_valid_q, s3_valid_q;
  letter_t  s1_letter_q, s2_letter_q, s3_letter_q;
  rcl_pos_t s1_pos_q, s2_pos_q;
  logic     s1_ready, s2_ready, s3_ready;
  letter_t  fwd_letter, rev_letter;

  // A stage takes new data when empty or when its content moves on
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Plugboard, slow -> middle -> fast, reflector
  always_comb begin
    letter_t c;
    c = plug_fwd(cfg_i.plug_pairs, cfg_i.plug_count, s1_letter_q);
    c = rotor_fwd(cfg_i.slow_sel,   s1_pos_q.slow,   c);
    c = rotor_fwd(cfg_i.middle_sel, s1_pos_q.middle, c);
    c = rotor_fwd(cfg_i.fast_sel,   s1_pos_q.fast,   c);
    fwd_letter = REFLECT[c];
  end

  // fast -> middle -> slow on the way back, reverse plugboard
  always_comb begin
    letter_t c;
    c = rotor_rev(cfg_i.fast_sel,   s2_pos_q.fast,   s2_letter_q);
    c = rotor_rev(cfg_i.middle_sel, s2_pos_q.middle, c);
    c = rotor_rev(cfg_i.slow_sel,   s2_pos_q.slow,   c);
    rev_letter = plug_rev(cfg_i.plug_pairs, cfg_i.plug_count, c);
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_letter_q <= in_letter_i;
      s1_pos_q    <= in_pos_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_letter_q <= fwd_letter;
      s2_pos_q    <= s1_pos_q;
    end
    if (s3_ready && s2_valid_q) begin
      s3_letter_q <= rev_letter;
    end
  end

  assign out_valid_o  = s3_valid_q;
  assign out_letter_o = s3_letter_q;

endmodule

// ===== src/rotor_cipher_letter.sv =====
// rotor_cipher_letter: top level of the three-rotor letter cipher. Holds the key
// registers and the rotor stepping; depends on rcl_pkg and rcl_rotor_path.

// Usage
//   Input channel (in_valid_i/in_ready_o) carries one plaintext letter 0..25 and
//   a new_message flag; a set flag reloads the three start positions and clears
//   the letter counter before that letter is enciphered.
//   Output channel (out_valid_o/out_ready_i) returns one enciphered letter per
//   input transaction, in order.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes one key register per
//   transaction, addressed by cfg_index_i; it is always ready. Write it only
//   while no letter is in flight.
//   A letter passes through the three pipeline registers (input, forward pass
//   with reflector, reverse pass) before output valid; throughput is one letter
//   per cycle while out_ready_i stays high.
//   Rotor positions step at the input transaction, so stepping waits on the
//   output side only when a stall has filled the stages and holds the input.
//   Reset returns the key registers to rotors III/II/I in the slow/middle/fast
//   slots, start positions 0, no plugs, and clears positions and counter.
//   When the receiver stalls, each stage holds its letter; the input side keeps
//   taking letters until the three stages are full.

module rotor_cipher_letter
  import rcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LETTER_W-1:0]   letter_in_i,
  input  logic                  new_message_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LETTER_W-1:0]   letter_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  rcl_cfg_t cfg_q;
  letter_t  fast_start_q, middle_start_q, slow_start_q;
  rcl_pos_t pos_q, pos_d, pos_use;
  letter_t  cnt_lo_q, cnt_lo_d, cnt_hi_q, cnt_hi_d;
  letter_t  cnt_lo_use, cnt_hi_use;
  logic     in_fire;
  logic     lo_wrap;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_sel   <= ROTOR_I;
      cfg_q.middle_sel <= ROTOR_II;
      cfg_q.slow_sel   <= ROTOR_III;
      cfg_q.plug_pairs <= '0;
      cfg_q.plug_count <= '0;
      fast_start_q     <= '0;
      middle_start_q   <= '0;
      slow_start_q     <= '0;
    end else if (cfg_valid_i) begin
      case (rcl_reg_e'(cfg_index_i))
        REG_FAST_ROTOR:   cfg_q.fast_sel   <= rcl_rotor_e'(cfg_data_i[1:0]);
        REG_MIDDLE_ROTOR: cfg_q.middle_sel <= rcl_rotor_e'(cfg_data_i[1:0]);
        REG_SLOW_ROTOR:   cfg_q.slow_sel   <= rcl_rotor_e'(cfg_data_i[1:0]);
        REG_FAST_START:   fast_start_q     <= cfg_data_i[LETTER_W-1:0];
        REG_MIDDLE_START: middle_start_q   <= cfg_data_i[LETTER_W-1:0];
        REG_SLOW_START:   slow_start_q     <= cfg_data_i[LETTER_W-1:0];
        REG_PLUG_PAIRS:   cfg_q.plug_pairs <= cfg_data_i[PLUG_W-1:0];
        REG_PLUG_COUNT:   cfg_q.plug_count <= cfg_data_i[PLUG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Positions for this letter: start values on a new message
  always_comb begin
    if (new_message_i) begin
      pos_use.fast   = fold_letter(fast_start_q);
      pos_use.middle = fold_letter(middle_start_q);
      pos_use.slow   = fold_letter(slow_start_q);
      cnt_lo_use     = '0;
      cnt_hi_use     = '0;
    end else begin
      pos_use    = pos_q;
      cnt_lo_use = cnt_lo_q;
      cnt_hi_use = cnt_hi_q;
    end
  end

  // Odometer stepping; the mod-676 counter is kept as two base-26 digits
  always_comb begin
    lo_wrap      = (cnt_lo_use == 5'd25);
    cnt_lo_d     = inc_mod26(cnt_lo_use);
    cnt_hi_d     = lo_wrap ? inc_mod26(cnt_hi_use) : cnt_hi_use;
    pos_d.fast   = inc_mod26(pos_use.fast);
    pos_d.middle = lo_wrap ? inc_mod26(pos_use.middle) : pos_use.middle;
    pos_d.slow   = (lo_wrap && (cnt_hi_use == 5'd25)) ? inc_mod26(pos_use.slow)
                                                      : pos_use.slow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
    end else if (in_fire) begin
      pos_q    <= pos_d;
      cnt_lo_q <= cnt_lo_d;
      cnt_hi_q <= cnt_hi_d;
    end
  end

  rcl_rotor_path u_rotor_path (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_letter_i  (fold_letter(letter_in_i)),
    .in_pos_i     (pos_use),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_letter_o (letter_out_o)
  );

endmodule

// ===== src/rcl_checker.sv =====
// rcl_checker: port-level assertions for rotor_cipher_letter and the bind that
// attaches them. Depends on rcl_pkg.

module rcl_checker
  import rcl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [LETTER_W-1:0] letter_out_o
);

  logic [1:0] inflight_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  // A result only shows up for an accepted letter
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != 2'd0))
    else $error("result without a pending letter");

  // Three stages: a full pipe must stall the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 2'd3) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with pipeline full");

  // Enciphered letters stay inside the alphabet
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_out_o <= 5'd25))
    else $error("letter out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(letter_out_o))
    else $error("stalled result dropped or changed");

endmodule

bind rotor_cipher_letter rcl_checker u_rcl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .letter_out_o (letter_out_o)
);
